>>> hw/rtl/msr_pkg.sv
// shared types and constants for the modular square root block
package msr_pkg;

	localparam int VALUE_W = 64;
	localparam logic [31:0] SEARCH_CAP = 32'd65536;

	typedef struct packed {
		logic [63:0] value;
		logic [31:0] modulus;
	} msr_arg_t;

	typedef struct packed {
		logic [31:0] root;
		logic        has_root;
	} msr_res_t;

	// sign of the quadratic character of two at an odd residue mod 8
	function automatic logic jac_neg(input logic [2:0] idx);
		return (idx == 3'd3) || (idx == 3'd5);
	endfunction

endpackage

>>> hw/rtl/msr_rem.sv
// shared iterative remainder unit, one numerator bit per cycle
module msr_rem #(
	parameter int W = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [msr_pkg::VALUE_W-1:0] num,
	input  logic [W-1:0]              den,
	output logic                      done,
	output logic [W-1:0]              rem
);
	localparam int CW = $clog2(msr_pkg::VALUE_W + 1);

	logic [msr_pkg::VALUE_W-1:0] n_q;
	logic [W-1:0]                d_q;
	logic [W-1:0]                r_q;
	logic [CW-1:0]               cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [W:0]                  t;
	logic [W:0]                  diff;

	assign t    = {r_q, n_q[msr_pkg::VALUE_W-1]};
	assign diff = t - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(msr_pkg::VALUE_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			d_q <= den;
			r_q <= '0;
		end else if (busy_q) begin
			n_q <= n_q << 1;
			if (t >= {1'b0, d_q}) begin
				r_q <= diff[W-1:0];
			end else begin
				r_q <= t[W-1:0];
			end
		end
	end

	assign done = done_q;
	assign rem  = r_q;
endmodule

>>> hw/rtl/modular_square_root_top.sv
// top level of the modular square root block (tonelli-shanks family)
//
// each request carries a 64-bit value and an odd prime modulus, of which the low MOD_WIDTH
// bits are used. the block reduces the value, finds its quadratic character with a binary
// jacobi loop and, for a residue, returns a square root (3 or 7 mod 8: one exponentiation,
// 5 mod 8: candidate root times a power of two if it misses, otherwise full tonelli-shanks with a
// search for a non-residue). a non-residue or a value divisible by the modulus gives root 0
// and has_root 0; modulus 1 gives root 0, has_root 1; modulus 0 gives 0, 0. a composite
// modulus gives a deterministic but meaningless root. every remainder is taken by one
// shared remainder unit that retires one bit per cycle: the reduction of the value, every
// jacobi step and every modular multiply. an exponentiation with an n-bit exponent takes
// at most 2n-1 multiplies. the time for 1 mod 8 grows with the two-adic order e of
// modulus-1 and with how far the non-residue search runs (each candidate is one full
// exponentiation). the block takes one request at a time and holds stall high until its
// result is loaded into the output register; a finished result may wait there while the
// next request is taken.
module modular_square_root_top #(
	parameter int MOD_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              arg_valid,
	output logic              arg_stall,
	input  msr_pkg::msr_arg_t arg,
	output logic              res_valid,
	input  logic              res_stall,
	output msr_pkg::msr_res_t res
);
	localparam int W  = MOD_WIDTH;
	localparam int EW = $clog2(W);

	typedef enum logic [5:0] {
		IDLE, RED, J_M2, J_X, J_X2, J_REM, J_END, ROOT,
		R37, R5A, R5B, R5C, R5D,
		TS, TS_Z, TS_ZC, TS_E, TS_F, TS_G, TS_H, TS_H1, TS_H2, TS_H3,
		TS_R1, TS_R2, TS_R3,
		PW_LOOP, PW_ACC, PW_SQ, PW_SQD,
		MUL, MWAIT, DONE
	} state_t;

	state_t state_q, pw_ret_q, mul_ret_q;

	// working registers
	logic [W-1:0]  m_q, a_q, jx_q, jm_q, q_q, z_q, f_q, gen_q, g_q, r_q;
	logic [W-1:0]  pb_q, pe_q, pacc_q, mx_q, my_q, mres_q;
	logic [EW-1:0] e_q, h_q;
	logic          tw_q, neg_q;
	logic [W-1:0]  root_q;
	logic          ok_q;
	logic          out_valid_q;
	msr_pkg::msr_res_t out_q;

	// shared remainder unit hookup
	logic                        rem_start, rem_done;
	logic [msr_pkg::VALUE_W-1:0] rem_num;
	logic [W-1:0]                rem_den, rem_val;
	logic [2*W-1:0]              prod;
	logic [W-1:0]                m_in;
	logic                        can_load;
	logic [W:0]                  m_ext;

	assign m_in     = arg.modulus[W-1:0];
	assign m_ext    = {1'b0, m_q};
	assign prod     = (2*W)'(mx_q) * (2*W)'(my_q);
	assign can_load = !out_valid_q || !res_stall;

	always_comb begin
		rem_start = 1'b0;
		rem_num   = msr_pkg::VALUE_W'(prod);
		rem_den   = m_q;
		unique case (state_q)
			IDLE: begin
				rem_start = arg_valid && (m_in > W'(1));
				rem_num   = arg.value;
				rem_den   = m_in;
			end
			J_X2: begin
				rem_start = jx_q[0];
				rem_num   = msr_pkg::VALUE_W'(jm_q);
				rem_den   = jx_q;
			end
			MUL: rem_start = 1'b1;
			default: ;
		endcase
	end

	msr_rem #(.W(W)) u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rem_start),
		.num    (rem_num),
		.den    (rem_den),
		.done   (rem_done),
		.rem    (rem_val)
	);

	assign arg_stall = (state_q != IDLE);
	assign res_valid = out_valid_q;
	assign res       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			pw_ret_q    <= IDLE;
			mul_ret_q   <= IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// result taken, unless the next one loads in this same cycle
			if (out_valid_q && !res_stall && state_q != DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (arg_valid) begin
						m_q    <= m_in;
						root_q <= '0;
						ok_q   <= (m_in == W'(1));
						if (m_in > W'(1)) begin
							state_q <= RED;
						end else begin
							state_q <= DONE;
						end
					end
				end
				RED: begin
					if (rem_done) begin
						a_q  <= rem_val;
						jx_q <= rem_val;
						jm_q <= m_q;
						tw_q <= 1'b0;
						if (rem_val == '0 || (!rem_val[0] && !m_q[0])) begin
							state_q <= DONE;
						end else begin
							state_q <= J_M2;
						end
					end
				end
				// strip twos from an even modulus
				J_M2: begin
					if (!jm_q[0]) begin
						jm_q <= jm_q >> 1;
						tw_q <= ~tw_q;
					end else begin
						neg_q   <= tw_q & msr_pkg::jac_neg(jx_q[2:0]);
						state_q <= J_X;
					end
				end
				J_X: begin
					tw_q <= 1'b0;
					if (jx_q == '0) begin
						state_q <= J_END;
					end else begin
						state_q <= J_X2;
					end
				end
				J_X2: begin
					if (!jx_q[0]) begin
						jx_q <= jx_q >> 1;
						tw_q <= ~tw_q;
					end else begin
						neg_q <= neg_q ^ (tw_q & msr_pkg::jac_neg(jm_q[2:0]))
							^ (jx_q[1] & jm_q[1]);
						state_q <= J_REM;
					end
				end
				J_REM: begin
					if (rem_done) begin
						jm_q    <= jx_q;
						jx_q    <= rem_val;
						state_q <= J_X;
					end
				end
				J_END: begin
					if (jm_q == W'(1) && !neg_q) begin
						ok_q    <= 1'b1;
						state_q <= ROOT;
					end else begin
						state_q <= DONE;
					end
				end
				ROOT: begin
					pacc_q  <= W'(1);
					pb_q    <= a_q;
					state_q <= PW_LOOP;
					unique case (m_q[2:0])
						3'd3, 3'd7: begin
							pe_q     <= W'((m_ext + 1'b1) >> 2);
							pw_ret_q <= R37;
						end
						3'd5: begin
							pe_q     <= W'((m_ext + 2'd3) >> 3);
							pw_ret_q <= R5A;
						end
						default: state_q <= TS;
					endcase
				end
				R37: begin
					root_q  <= pacc_q;
					state_q <= DONE;
				end
				R5A: begin
					r_q       <= pacc_q;
					mx_q      <= pacc_q;
					my_q      <= pacc_q;
					mul_ret_q <= R5B;
					state_q   <= MUL;
				end
				R5B: begin
					if (mres_q != a_q) begin
						pb_q     <= W'(2);
						pe_q     <= (m_q - 1'b1) >> 2;
						pacc_q   <= W'(1);
						pw_ret_q <= R5C;
						state_q  <= PW_LOOP;
					end else begin
						root_q  <= r_q;
						state_q <= DONE;
					end
				end
				R5C: begin
					mx_q      <= r_q;
					my_q      <= pacc_q;
					mul_ret_q <= R5D;
					state_q   <= MUL;
				end
				R5D: begin
					root_q  <= mres_q;
					state_q <= DONE;
				end
				TS: begin
					if (a_q == W'(1)) begin
						root_q  <= W'(1);
						state_q <= DONE;
					end else begin
						q_q     <= m_q - 1'b1;
						z_q     <= W'(2);
						e_q     <= '0;
						state_q <= TS_Z;
					end
				end
				// non-residue search
				TS_Z: begin
					if (z_q < m_q && 32'(z_q) < msr_pkg::SEARCH_CAP) begin
						pb_q     <= z_q;
						pe_q     <= q_q >> 1;
						pacc_q   <= W'(1);
						pw_ret_q <= TS_ZC;
						state_q  <= PW_LOOP;
					end else begin
						z_q     <= '0;
						state_q <= TS_E;
					end
				end
				TS_ZC: begin
					if (pacc_q == q_q) begin
						state_q <= TS_E;
					end else begin
						z_q     <= z_q + 1'b1;
						state_q <= TS_Z;
					end
				end
				TS_E: begin
					if (q_q != '0 && !q_q[0]) begin
						q_q <= q_q >> 1;
						e_q <= e_q + 1'b1;
					end else begin
						pb_q     <= a_q;
						pe_q     <= q_q;
						pacc_q   <= W'(1);
						pw_ret_q <= TS_F;
						state_q  <= PW_LOOP;
					end
				end
				TS_F: begin
					f_q      <= pacc_q;
					pb_q     <= z_q;
					pe_q     <= q_q;
					pacc_q   <= W'(1);
					pw_ret_q <= TS_G;
					state_q  <= PW_LOOP;
				end
				TS_G: begin
					gen_q   <= pacc_q;
					g_q     <= '0;
					h_q     <= '0;
					state_q <= TS_H;
				end
				TS_H: begin
					pacc_q  <= W'(1);
					state_q <= PW_LOOP;
					if (h_q < e_q) begin
						pb_q     <= gen_q;
						pe_q     <= g_q;
						pw_ret_q <= TS_H1;
					end else begin
						pb_q     <= a_q;
						pe_q     <= W'(({1'b0, q_q} + 1'b1) >> 1);
						pw_ret_q <= TS_R1;
					end
				end
				TS_H1: begin
					mx_q      <= pacc_q;
					my_q      <= f_q;
					mul_ret_q <= TS_H2;
					state_q   <= MUL;
				end
				TS_H2: begin
					pb_q     <= mres_q;
					pe_q     <= W'(1) << (e_q - h_q - 1'b1);
					pacc_q   <= W'(1);
					pw_ret_q <= TS_H3;
					state_q  <= PW_LOOP;
				end
				TS_H3: begin
					if (pacc_q == m_q - 1'b1) begin
						g_q <= g_q | (W'(1) << h_q);
					end
					h_q     <= h_q + 1'b1;
					state_q <= TS_H;
				end
				TS_R1: begin
					r_q      <= pacc_q;
					pb_q     <= gen_q;
					pe_q     <= g_q >> 1;
					pacc_q   <= W'(1);
					pw_ret_q <= TS_R2;
					state_q  <= PW_LOOP;
				end
				TS_R2: begin
					mx_q      <= r_q;
					my_q      <= pacc_q;
					mul_ret_q <= TS_R3;
					state_q   <= MUL;
				end
				TS_R3: begin
					root_q  <= mres_q;
					state_q <= DONE;
				end
				// square and multiply, lsb first
				PW_LOOP: begin
					if (pe_q == '0) begin
						state_q <= pw_ret_q;
					end else if (pe_q[0]) begin
						mx_q      <= pacc_q;
						my_q      <= pb_q;
						mul_ret_q <= PW_ACC;
						state_q   <= MUL;
					end else begin
						state_q <= PW_SQ;
					end
				end
				PW_ACC: begin
					pacc_q  <= mres_q;
					state_q <= PW_SQ;
				end
				PW_SQ: begin
					if (pe_q == W'(1)) begin
						pe_q    <= '0;
						state_q <= PW_LOOP;
					end else begin
						mx_q      <= pb_q;
						my_q      <= pb_q;
						mul_ret_q <= PW_SQD;
						state_q   <= MUL;
					end
				end
				PW_SQD: begin
					pb_q    <= mres_q;
					pe_q    <= pe_q >> 1;
					state_q <= PW_LOOP;
				end
				MUL: state_q <= MWAIT;
				MWAIT: begin
					if (rem_done) begin
						mres_q  <= rem_val;
						state_q <= mul_ret_q;
					end
				end
				DONE: begin
					if (can_load) begin
						out_q.root     <= 32'(root_q);
						out_q.has_root <= ok_q;
						out_valid_q    <= 1'b1;
						state_q        <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule

>>> bench/tb_top.sv
// self-checking testbench for the modular square root block
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef longint unsigned u64;

	// one directed row: request plus an optional typed-in answer
	typedef struct {
		u64   value;
		u64   modulus;
		bit   fixed;
		u64   root;
		bit   has_root;
	} dir_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              arg_valid = 1'b0;
	logic              arg_stall;
	msr_pkg::msr_arg_t arg = '0;
	logic              res_valid;
	logic              res_stall = 1'b0;
	msr_pkg::msr_res_t res;

	// answers still owed by the block, oldest first
	msr_pkg::msr_res_t root_q[$];
	int       errors = 0;
	int       n_req = 0;
	int       n_res = 0;
	int       n_residue = 0;
	int       res_gap = 0;

	modular_square_root_top u_top (
		.clk(clk), .arst_n(arst_n),
		.arg_valid(arg_valid), .arg_stall(arg_stall), .arg(arg),
		.res_valid(res_valid), .res_stall(res_stall), .res(res)
	);

	always #4 clk = ~clk;

	// modular arithmetic, operands below 2^32 so products fit in 64 bits
	function automatic u64 mod_mul(u64 x, u64 y, u64 m);
		return ((x % m) * (y % m)) % m;
	endfunction

	function automatic u64 mod_pow(u64 b, u64 ex, u64 m);
		u64 acc;
		acc = 1 % m;
		b = b % m;
		while (ex != 0) begin
			if (ex[0])
				acc = mod_mul(acc, b, m);
			b = mod_mul(b, b, m);
			ex = ex >> 1;
		end
		return acc;
	endfunction

	// sign of the character of two indexed by low three bits
	function automatic int two_sign(u64 v);
		case (v[2:0])
			3'd1, 3'd7: return 1;
			3'd3, 3'd5: return -1;
			default: return 0;
		endcase
	endfunction

	// binary jacobi/kronecker symbol, x below m
	function automatic int jacobi_sym(u64 x, u64 m);
		int unsigned tw;
		int          s;
		u64          t;
		if (x == 0 || m == 0)
			return ((x | m) == 1) ? 1 : 0;
		if (((x | m) & 1) == 0)
			return 0;
		tw = 0;
		while (!m[0]) begin
			m = m >> 1;
			tw++;
		end
		s = tw[0] ? two_sign(x) : 1;
		while (x != 0) begin
			tw = 0;
			while (!x[0]) begin
				x = x >> 1;
				tw++;
			end
			if (tw[0])
				s = s * two_sign(m);
			if ((x & m & 2) != 0)
				s = -s;
			t = m % x;
			m = x;
			x = t;
		end
		return (m == 1) ? s : 0;
	endfunction

	// root of a residue a, method picked by the modulus mod 8
	function automatic u64 residue_root(u64 a, u64 m);
		u64          r, q, z, f, gen, g, d;
		int unsigned e;
		case (m[2:0])
			3'd3, 3'd7: return mod_pow(a, (m + 1) >> 2, m);
			3'd5: begin
				r = mod_pow(a, (m + 3) >> 3, m);
				if (mod_mul(r, r, m) != a)
					r = mod_mul(r, mod_pow(2, (m - 1) >> 2, m), m);
				return r;
			end
			default: ;
		endcase
		if (a == 1)
			return 1;
		q = m - 1;
		z = 2;
		while (z < m && z < msr_pkg::SEARCH_CAP && mod_pow(z, q >> 1, m) != q)
			z++;
		if (!(z < m && z < msr_pkg::SEARCH_CAP))
			z = 0;
		e = 0;
		while (q != 0 && !q[0]) begin
			q = q >> 1;
			e++;
		end
		f = mod_pow(a, q, m);
		gen = mod_pow(z, q, m);
		g = 0;
		for (int unsigned h = 0; h < e; h++) begin
			d = mod_mul(mod_pow(gen, g, m), f, m);
			d = mod_pow(d, u64'(1) << (e - h - 1), m);
			if (d == m - 1)
				g += u64'(1) << h;
		end
		f = mod_pow(a, (q + 1) >> 1, m);
		return mod_mul(f, mod_pow(gen, g >> 1, m), m);
	endfunction

	function automatic msr_pkg::msr_res_t predict_root(u64 value, u64 modulus);
		msr_pkg::msr_res_t o;
		u64       a;
		o = '0;
		if (modulus == 1) begin
			o.has_root = 1'b1;
		end else if (modulus >= 2) begin
			a = value % modulus;
			if (jacobi_sym(a, modulus) == 1) begin
				o.has_root = 1'b1;
				o.root = 32'(residue_root(a, modulus));
			end
		end
		return o;
	endfunction

	// send one request after a random gap; valid only drops when a gap follows
	task automatic send_req(u64 value, u64 modulus, bit fixed,
		msr_pkg::msr_res_t answer);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			arg_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		arg_valid <= 1'b1;
		arg.value <= value;
		arg.modulus <= 32'(modulus);
		@(posedge clk);
		while (arg_stall)
			@(posedge clk);
		root_q.push_back(fixed ? answer : predict_root(value, modulus));
		n_req++;
	endtask

	// result side: check each accepted result, then draw the next stall stretch
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				n_res++;
				if (root_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result root=%0d has_root=%0b",
						$realtime, res.root, res.has_root);
				end else begin
					if (res.root !== root_q[0].root) begin
						errors++;
						$display("%0t: root expected %0d actual %0d",
							$realtime, root_q[0].root, res.root);
					end
					if (res.has_root !== root_q[0].has_root) begin
						errors++;
						$display("%0t: has_root expected %0b actual %0b",
							$realtime, root_q[0].has_root, res.has_root);
					end
					if (root_q[0].has_root)
						n_residue++;
					void'(root_q.pop_front());
				end
				res_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
				res_stall <= (res_gap != 0);
			end else if (res_gap > 0) begin
				res_gap--;
				res_stall <= (res_gap != 0);
			end
		end
	end

	// pick a modulus class for a random request
	function automatic u64 rand_modulus();
		u64 primes_1mod8[10] = '{17, 41, 73, 97, 113, 193, 257, 12289, 65537,
			64'd4294967161};
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0, 1, 2, 3: return ({$urandom} & 32'hFFFF_FFF8) | ($urandom_range(0, 1) ? 3 : 7);
			4:          return ({$urandom} & 32'hFFFF_FFF8) | 5;
			5, 6:       return ($urandom_range(8, 65535) & 16'hFFF8) |
					(($urandom_range(0, 2) * 2) + 3);
			7, 8:       return primes_1mod8[$urandom_range(0, 9)];
			default:    return $urandom_range(0, 64);
		endcase
	endfunction

	initial begin
		dir_row_t          rows[$];
		u64                v, m, r;
		msr_pkg::msr_res_t ans;

		// directed rows: degenerate moduli, extremes, one of each mod-8 class
		rows = '{
			'{64'd5, 64'd0, 1'b1, 64'd0, 1'b0},
			'{64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 1'b1, 64'd0, 1'b0},
			'{64'd12345, 64'd1, 1'b1, 64'd0, 1'b1},
			'{64'd0, 64'd7, 1'b1, 64'd0, 1'b0},
			'{64'd14, 64'd7, 1'b1, 64'd0, 1'b0},
			'{64'd4, 64'd7, 1'b1, 64'd2, 1'b1},
			'{64'd3, 64'd7, 1'b1, 64'd0, 1'b0},
			'{64'hFFFF_FFFF_FFFF_FFFF, 64'd3, 1'b1, 64'd0, 1'b0},
			'{64'd1, 64'd4294967161, 1'b1, 64'd1, 1'b1},
			'{64'd4294967291 * 64'd7, 64'd4294967291, 1'b1, 64'd0, 1'b0},
			'{64'hFFFF_FFFF_FFFF_FFFF, 64'd4294967291, 1'b0, 64'd0, 1'b0},
			'{64'hFFFF_FFFF_FFFF_FFFF, 64'd4294967279, 1'b0, 64'd0, 1'b0},
			'{64'hFFFF_FFFF_FFFF_FFFF, 64'd4294967197, 1'b0, 64'd0, 1'b0},
			'{64'd2, 64'd4294967197, 1'b0, 64'd0, 1'b0},
			'{64'hFFFF_FFFF_FFFF_FFFF, 64'd4294967161, 1'b0, 64'd0, 1'b0},
			'{64'd10, 64'd17, 1'b0, 64'd0, 1'b0},
			'{64'd3, 64'd65537, 1'b0, 64'd0, 1'b0},
			'{64'd2, 64'd257, 1'b0, 64'd0, 1'b0},
			'{64'd7, 64'd12289, 1'b0, 64'd0, 1'b0},
			'{64'd3, 64'd2, 1'b0, 64'd0, 1'b0},
			'{64'd5, 64'd4, 1'b0, 64'd0, 1'b0},
			'{64'd7, 64'd9, 1'b0, 64'd0, 1'b0},
			'{64'd11, 64'd15, 1'b0, 64'd0, 1'b0},
			'{64'hFFFF_FFFF_0000_0000, 64'hFFFF_FFFF, 1'b0, 64'd0, 1'b0}
		};

		// reset held at first, inputs already at known values
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			ans.root = 32'(rows[i].root);
			ans.has_root = rows[i].has_root;
			send_req(rows[i].value, rows[i].modulus, rows[i].fixed, ans);
		end

		// random part: half of the values are squares so the root paths get exercised
		for (int i = 0; i < 150; i++) begin
			m = rand_modulus();
			r = {$urandom};
			case ($urandom_range(0, 3))
				0, 1:    v = r * r;
				2:       v = {$urandom, $urandom};
				default: v = $urandom_range(0, 300);
			endcase
			if (i == 75) begin
				// drain the block completely before going on
				arg_valid <= 1'b0;
				while (root_q.size() != 0)
					@(posedge clk);
			end
			send_req(v, m, 1'b0, ans);
		end
		arg_valid <= 1'b0;

		// wait for the last answers, then a tail for anything stray
		while (root_q.size() != 0)
			@(posedge clk);
		repeat (20000) @(posedge clk);

		$display("covered %0d requests, %0d results, %0d with a root", n_req, n_res,
			n_residue);
		$display("moduli spanned all mod-8 classes, zero, one, even and composite values");
		if (errors == 0 && root_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// watchdog
	initial begin
		#200_000_000;
		$display("watchdog expired with %0d results outstanding", root_q.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/msr_pkg.sv
hw/rtl/msr_rem.sv
hw/rtl/modular_square_root_top.sv
bench/tb_top.sv
